FILE: hw/rtl/uvsg_pkg.sv
package uvsg_pkg;

  // Q30 fixed point: 1.0 and 2*pi/4 scaled (remainder phase to radians)
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;

  // Horner steps: sine steps first, then cosine steps
  localparam int SIN_STEPS = 6;
  localparam int COS_STEPS = 7;
  localparam int ALL_STEPS = SIN_STEPS + COS_STEPS;

  // Latency of the sine/cosine unit, phase in to result registered
  localparam int SC_LAT = 24;

  // Configuration register indexes
  localparam logic [1:0] REG_SLICES = 2'd0;
  localparam logic [1:0] REG_STACKS = 2'd1;

  // Per-item flags carried down the pipeline
  typedef struct packed {
    logic in_range;
    logic pole;
    logic top;
  } flags_t;

  // Series divisor for Horner step j (sine steps, then cosine steps)
  function automatic logic [7:0] step_div(input int j);
    logic [7:0] d;
    case (j)
      0:       d = 8'd156;
      1:       d = 8'd110;
      2:       d = 8'd72;
      3:       d = 8'd42;
      4:       d = 8'd20;
      5:       d = 8'd6;
      6:       d = 8'd182;
      7:       d = 8'd132;
      8:       d = 8'd90;
      9:       d = 8'd56;
      10:      d = 8'd30;
      11:      d = 8'd12;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

endpackage

FILE: hw/rtl/uvsg_sincos.sv
module uvsg_sincos import uvsg_pkg::*; (
  input  logic               clk,
  input  logic [31:0]        phase,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);

  // Remainder angle in radians and its square
  logic [1:0]  quad1;
  logic [30:0] a1;
  logic [60:0] a_prod;
  logic [61:0] a2_prod;
  assign a_prod  = 61'(phase[29:0]) * 61'(TWO_PI_Q28);
  assign a2_prod = 62'(a1) * 62'(a1);

  logic [31:0] a2_dly [19];
  logic [30:0] a_dly  [19];
  logic [1:0]  quad_dly [22];

  always_ff @(posedge clk) begin
    quad1 <= phase[31:30];
    a1    <= a_prod[60:30];
    a2_dly[0]   <= a2_prod[61:30];
    a_dly[0]    <= a1;
    quad_dly[0] <= quad1;
    for (int i = 1; i < 19; i++) begin
      a2_dly[i] <= a2_dly[i-1];
      a_dly[i]  <= a_dly[i-1];
    end
    for (int i = 1; i < 22; i++) begin
      quad_dly[i] <= quad_dly[i-1];
    end
  end

  // Horner steps, three stages each: a2*h, reciprocal multiply, correction
  logic [31:0] hx1 [ALL_STEPS];
  logic [31:0] hx2 [ALL_STEPS];
  logic [31:0] hq0 [ALL_STEPS];
  logic [30:0] hh  [ALL_STEPS];

  for (genvar j = 0; j < ALL_STEPS; j++) begin : g_step
    localparam logic [7:0]  D  = step_div(j);
    localparam logic [31:0] M  = 32'((64'd1 << 32) / 64'(D));
    localparam int          AI = (j < SIN_STEPS) ? 3 * j : 3 * (j - SIN_STEPS);

    logic [30:0] hin;
    logic [62:0] p1;
    logic [63:0] p2;
    logic [39:0] p3;
    logic [31:0] rem;
    logic [31:0] pq;

    if (j == 0 || j == SIN_STEPS) begin : g_first
      assign hin = Q30_ONE;
    end else begin : g_next
      assign hin = hh[j-1];
    end

    assign p1 = 63'(a2_dly[AI]) * 63'(hin);
    assign p2 = 64'(hx1[j]) * 64'(M);
    assign p3 = 40'(hq0[j]) * 40'(D);

    always_comb begin
      rem = hx2[j] - p3[31:0];
      pq  = (rem >= 32'(D)) ? hq0[j] + 32'd1 : hq0[j];
    end

    always_ff @(posedge clk) begin
      hx1[j] <= p1[61:30];
      hq0[j] <= p2[63:32];
      hx2[j] <= hx1[j];
      hh[j]  <= (pq >= 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - pq);
    end
  end

  // Sine = a * series, then align with cosine
  logic [61:0] s_prod;
  logic [30:0] sin_p, sin_d1, sin_d2;
  logic [31:0] s_pos, c_pos;
  assign s_prod = 62'(a_dly[18]) * 62'(hh[SIN_STEPS-1]);
  assign s_pos  = {1'b0, sin_d2};
  assign c_pos  = {1'b0, hh[ALL_STEPS-1]};

  always_ff @(posedge clk) begin
    sin_p  <= s_prod[60:30];
    sin_d1 <= sin_p;
    sin_d2 <= sin_d1;
    case (quad_dly[21])
      2'd0: begin
        sin_q <= s_pos;
        cos_q <= c_pos;
      end
      2'd1: begin
        sin_q <= c_pos;
        cos_q <= -s_pos;
      end
      2'd2: begin
        sin_q <= -s_pos;
        cos_q <= -c_pos;
      end
      default: begin
        sin_q <= -c_pos;
        cos_q <= s_pos;
      end
    endcase
  end

endmodule

FILE: hw/rtl/uv_sphere_vertex_generator_top.sv
// UV-sphere vertex generator. Give a vertex number with start; after the pipeline
// done pulses for one cycle with pos_x/pos_y/pos_z (signed, COORD_FRAC_BITS
// fraction bits) and in_range. A new vertex may be started every cycle and
// busy never rises; the result is shown for one cycle only and cannot be held
// off, so the receiver must take it when done is high. Each vertex passes through
// the pipelined dividers (ring split, then longitude and latitude phases) and
// the 13-step Horner sine/cosine pipeline. Write slices/stacks only while no
// vertex is in flight; ring_r and count_r are registered from the new value.
module uv_sphere_vertex_generator_top import uvsg_pkg::*; #(
  parameter int MAX_SLICES      = 1024,
  parameter int MAX_STACKS      = 1024,
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        vertex_number,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  output logic               done,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic               in_range
);

  localparam int          SH       = 30 - COORD_FRAC_BITS;
  localparam int          RND      = (2 ** SH) / 2;
  localparam logic [15:0] POLE_POS = 16'(64'd1 << COORD_FRAC_BITS);
  localparam logic [15:0] POLE_NEG = 16'(64'd0 - (64'd1 << COORD_FRAC_BITS));
  localparam int          FL_N     = 41;

  function automatic logic [15:0] to_field(input logic neg, input logic [32:0] m);
    logic [33:0] r;
    r = (34'(m) + 34'(RND)) >> SH;
    return neg ? 16'(34'd0 - r) : 16'(r);
  endfunction

  assign busy = 1'b0;

  // Configuration registers, saturated on write
  logic [10:0] slices_r, stacks_r, ring_r;
  logic [21:0] count_r;
  logic [10:0] sl_sat, st_sat;
  logic [21:0] cnt_prod;

  always_comb begin
    if (cfg_data < 11'd3) begin
      sl_sat = 11'd3;
    end else if (32'(cfg_data) > MAX_SLICES) begin
      sl_sat = 11'(MAX_SLICES);
    end else begin
      sl_sat = cfg_data;
    end
    if (cfg_data < 11'd2) begin
      st_sat = 11'd2;
    end else if (32'(cfg_data) > MAX_STACKS) begin
      st_sat = 11'(MAX_STACKS);
    end else begin
      st_sat = cfg_data;
    end
  end

  assign cnt_prod = 22'(slices_r) * 22'(stacks_r - 11'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      slices_r <= 11'd16;
      stacks_r <= 11'd16;
      ring_r   <= 11'd15;
      count_r  <= 22'd242;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SLICES: slices_r <= sl_sat;
          REG_STACKS: stacks_r <= st_sat;
          default: ;
        endcase
      end
      ring_r  <= stacks_r - 11'd1;
      count_r <= cnt_prod + 22'd2;
    end
  end

  // Valid bits and flags
  logic         v1;
  logic [19:0]  k1;
  logic [FL_N-1:0] vld;
  flags_t       fl [FL_N];
  logic [19:0]  km2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      vld  <= '0;
      done <= 1'b0;
    end else begin
      v1   <= start & ~busy;
      vld  <= {vld[FL_N-2:0], v1};
      done <= vld[FL_N-1];
    end
  end

  always_ff @(posedge clk) begin
    k1 <= vertex_number;
    km2 <= k1 - 20'd2;
    fl[0].in_range <= 22'(k1) < count_r;
    fl[0].pole     <= k1 < 20'd2;
    fl[0].top      <= k1 == 20'd0;
    for (int i = 1; i < FL_N; i++) begin
      fl[i] <= fl[i-1];
    end
  end

  // Ring split: (k-2) / ring, three quotient bits a stage
  logic [10:0] d1_r [4];
  logic [11:0] d1_q [4];
  logic [11:0] d1_l [4];

  for (genvar g = 0; g < 4; g++) begin : g_div1
    logic [10:0] r_in, rr;
    logic [11:0] q_in, qq, l_in, ll;
    logic [11:0] rw;

    if (g == 0) begin : g_first
      assign r_in = 11'(km2[19:12]);
      assign q_in = '0;
      assign l_in = km2[11:0];
    end else begin : g_next
      assign r_in = d1_r[g-1];
      assign q_in = d1_q[g-1];
      assign l_in = d1_l[g-1];
    end

    always_comb begin
      rr = r_in;
      qq = q_in;
      ll = l_in;
      rw = '0;
      for (int b = 0; b < 3; b++) begin
        rw = {rr, ll[11]};
        ll = {ll[10:0], 1'b0};
        if (rw >= {1'b0, ring_r}) begin
          rw = rw - {1'b0, ring_r};
          qq = {qq[10:0], 1'b1};
        end else begin
          qq = {qq[10:0], 1'b0};
        end
        rr = rw[10:0];
      end
    end

    always_ff @(posedge clk) begin
      d1_r[g] <= rr;
      d1_q[g] <= qq;
      d1_l[g] <= ll;
    end
  end

  // Slice and stack numbers
  logic [10:0] s7, t7;
  always_ff @(posedge clk) begin
    s7 <= d1_q[3][10:0];
    t7 <= d1_r[3] + 11'd1;
  end

  // Phase dividers: n * 2^32 / d, four quotient bits a stage
  logic [10:0] lon_r [8];
  logic [31:0] lon_q [8];
  logic [10:0] lat_r [8];
  logic [31:0] lat_q [8];

  for (genvar g = 0; g < 8; g++) begin : g_div2
    logic [10:0] lo_in, la_in, lo_rr, la_rr;
    logic [31:0] loq_in, laq_in, lo_qq, la_qq;
    logic [11:0] lo_w, la_w;

    if (g == 0) begin : g_first
      assign lo_in  = s7;
      assign la_in  = t7;
      assign loq_in = '0;
      assign laq_in = '0;
    end else begin : g_next
      assign lo_in  = lon_r[g-1];
      assign la_in  = lat_r[g-1];
      assign loq_in = lon_q[g-1];
      assign laq_in = lat_q[g-1];
    end

    always_comb begin
      lo_rr = lo_in;
      la_rr = la_in;
      lo_qq = loq_in;
      la_qq = laq_in;
      lo_w  = '0;
      la_w  = '0;
      for (int b = 0; b < 4; b++) begin
        lo_w = {lo_rr, 1'b0};
        if (lo_w >= {1'b0, slices_r}) begin
          lo_w  = lo_w - {1'b0, slices_r};
          lo_qq = {lo_qq[30:0], 1'b1};
        end else begin
          lo_qq = {lo_qq[30:0], 1'b0};
        end
        lo_rr = lo_w[10:0];
        la_w = {la_rr, 1'b0};
        if (la_w >= {1'b0, stacks_r}) begin
          la_w  = la_w - {1'b0, stacks_r};
          la_qq = {la_qq[30:0], 1'b1};
        end else begin
          la_qq = {la_qq[30:0], 1'b0};
        end
        la_rr = la_w[10:0];
      end
    end

    always_ff @(posedge clk) begin
      lon_r[g] <= lo_rr;
      lon_q[g] <= lo_qq;
      lat_r[g] <= la_rr;
      lat_q[g] <= la_qq;
    end
  end

  // Longitude and latitude phases
  logic [31:0] ph_lon, ph_lat;
  always_ff @(posedge clk) begin
    ph_lon <= lon_q[7];
    ph_lat <= 32'(Q30_ONE) - {1'b0, lat_q[7][31:1]};
  end

  logic signed [31:0] slon, clon, slat, clat;

  uvsg_sincos u_sc_lon (
    .clk   (clk),
    .phase (ph_lon),
    .sin_q (slon),
    .cos_q (clon)
  );

  uvsg_sincos u_sc_lat (
    .clk   (clk),
    .phase (ph_lat),
    .sin_q (slat),
    .cos_q (clat)
  );

  // Products on magnitudes, rounded half away from zero
  logic [31:0] m_clon, m_slon, m_clat;
  logic [63:0] px, pz;
  logic        nx41, nz41, nx42, nz42;
  logic signed [31:0] sl41, sl42;
  logic [32:0] mx42, mz42, my42;

  assign m_clon = clon[31] ? 32'(-clon) : 32'(clon);
  assign m_slon = slon[31] ? 32'(-slon) : 32'(slon);
  assign m_clat = clat[31] ? 32'(-clat) : 32'(clat);

  always_ff @(posedge clk) begin
    px   <= 64'(m_clon) * 64'(m_clat);
    pz   <= 64'(m_slon) * 64'(m_clat);
    nx41 <= clon[31] ^ clat[31];
    nz41 <= slon[31] ^ clat[31];
    sl41 <= slat;
    mx42 <= 33'((px + 64'd536870912) >> 30);
    mz42 <= 33'((pz + 64'd536870912) >> 30);
    my42 <= sl41[31] ? 33'(32'(-sl41)) : 33'(32'(sl41));
    nx42 <= nx41;
    nz42 <= nz41;
    sl42 <= sl41;
  end

  // Output register: range and pole cases override the datapath
  always_ff @(posedge clk) begin
    in_range <= fl[FL_N-1].in_range;
    if (!fl[FL_N-1].in_range) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (fl[FL_N-1].pole) begin
      pos_x <= '0;
      pos_y <= fl[FL_N-1].top ? POLE_POS : POLE_NEG;
      pos_z <= '0;
    end else begin
      pos_x <= to_field(nx42, mx42);
      pos_y <= to_field(sl42[31], my42);
      pos_z <= to_field(nz42, mz42);
    end
  end

endmodule
